>>> sv/itr_pkg.sv
`timescale 1ns / 1ps
package itr_pkg;

    localparam int unsigned DIGIT_BITS = 6;
    localparam int unsigned RADIX_BITS = 6;
    localparam int unsigned CHAR_BITS  = 8;
    // Quotient bits resolved per divider cycle.
    localparam int unsigned STEP_BITS  = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;
    localparam logic [CHAR_BITS-1:0]  MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_BITS-1:0]  ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_BITS-1:0]  ALPHA_CHAR = 8'h61;
    localparam logic [DIGIT_BITS-1:0] TEN        = 6'd10;

    typedef struct packed {
        logic neg;
        logic bad;
    } t_cls;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < TEN) begin
            c = ZERO_CHAR + CHAR_BITS'(d);
        end else begin
            c = ALPHA_CHAR + CHAR_BITS'(d - TEN);
        end
        return c;
    endfunction

endpackage

>>> sv/itr_if.sv
`timescale 1ns / 1ps
interface itr_in_if #(
    parameter int unsigned VALUE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_BITS-1:0]  value;
    logic [5:0]                    radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    logic       bad_radix;

    modport source (output valid, output character, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last, input bad_radix,
                    output ready);
endinterface

>>> sv/itr_front.sv
`timescale 1ns / 1ps
module itr_front
    import itr_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32,
    localparam int unsigned ITEM_W    = VALUE_BITS + RADIX_BITS + $bits(t_cls)
) (
    itr_in_if.sink           i_in,
    output logic             o_push,
    output logic [ITEM_W-1:0] o_push_data,
    input  logic             i_full
);

    logic                  neg;
    logic                  bad;
    logic [VALUE_BITS-1:0] mag;
    t_cls                  cls;

    // The most negative value negates to itself, which read unsigned is its magnitude.
    assign neg = i_in.value[VALUE_BITS-1];
    assign mag = neg ? VALUE_BITS'(-i_in.value) : VALUE_BITS'(i_in.value);
    assign bad = (i_in.radix < RADIX_MIN) || (i_in.radix > RADIX_MAX);

    always_comb begin
        cls.neg = neg;
        cls.bad = bad;
    end

    assign i_in.ready   = !i_full;
    assign o_push       = i_in.valid && !i_full;
    assign o_push_data  = {mag, i_in.radix, cls};

endmodule

>>> sv/itr_fifo.sv
`timescale 1ns / 1ps
module itr_fifo #(
    parameter int unsigned WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> sv/itr_back.sv
`timescale 1ns / 1ps
module itr_back
    import itr_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32,
    localparam int unsigned ITEM_W    = VALUE_BITS + RADIX_BITS + $bits(t_cls)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [ITEM_W-1:0] i_data,
    output logic              o_pop,
    itr_out_if.source         o_out
);

    localparam int unsigned STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int unsigned PAD    = STEPS * STEP_BITS;
    localparam int unsigned CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int unsigned DEP_W  = $clog2(VALUE_BITS + 1);
    localparam int unsigned ADDR_W = $clog2(VALUE_BITS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_ERR  = 6'b000100,
        S_SIGN = 6'b001000,
        S_READ = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [PAD-1:0]        r_quo;
    logic [DIGIT_BITS-1:0] r_rem;
    logic [RADIX_BITS-1:0] r_radix;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic [DEP_W-1:0]      r_depth;
    logic [DIGIT_BITS-1:0] r_stack [VALUE_BITS];
    logic [DIGIT_BITS-1:0] r_rd;

    logic                  r_ov;
    logic [CHAR_BITS-1:0]  r_ochar;
    logic                  r_olast;
    logic                  r_obad;

    logic [VALUE_BITS-1:0] in_mag;
    logic [RADIX_BITS-1:0] in_radix;
    t_cls                  in_cls;

    logic [DIGIT_BITS:0]   trial;
    logic [DIGIT_BITS-1:0] rem_c;
    logic [STEP_BITS-1:0]  qbits;
    logic [STEP_BITS-1:0]  chunk;
    logic [PAD-1:0]        quo_next;
    logic                  last_step;
    logic [DEP_W-1:0]      depth_m1;
    logic                  out_free;

    assign {in_mag, in_radix, in_cls} = i_data;
    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign out_free  = !r_ov || o_out.ready;
    assign last_step = (r_cnt == CNT_W'(STEPS - 1));
    assign depth_m1  = r_depth - DEP_W'(1);

    // Restoring division, STEP_BITS quotient bits per cycle, MSB first.
    // Quotient bits shift in at the bottom as dividend bits leave the top.
    always_comb begin
        chunk = r_quo[PAD-1 -: STEP_BITS];
        rem_c = r_rem;
        qbits = '0;
        trial = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_c, chunk[STEP_BITS-1-i]};
            if (trial >= {1'b0, r_radix}) begin
                trial = trial - {1'b0, r_radix};
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            rem_c = trial[DIGIT_BITS-1:0];
        end
        quo_next = (r_quo << STEP_BITS) | PAD'(qbits);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = in_cls.bad ? S_ERR : S_DIV;
                end
            end
            S_DIV: begin
                if (last_step && (quo_next == '0)) begin
                    n_state = S_SIGN;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SIGN: begin
                if (!r_neg || out_free) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_depth == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_depth <= '0;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    if (last_step) begin
                        r_depth <= r_depth + DEP_W'(1);
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_READ: begin
                    r_depth <= depth_m1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo   <= PAD'(in_mag);
            r_rem   <= '0;
            r_radix <= in_radix;
            r_neg   <= in_cls.neg;
        end else if (r_state == S_DIV) begin
            r_quo <= quo_next;
            r_rem <= last_step ? '0 : rem_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && last_step) begin
            r_stack[r_depth[ADDR_W-1:0]] <= rem_c;
        end
        if (r_state == S_READ) begin
            r_rd <= r_stack[depth_m1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free && ((r_state == S_ERR) || (r_state == S_EMIT)
                                  || ((r_state == S_SIGN) && r_neg))) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_state == S_ERR) begin
                r_ochar <= '0;
                r_olast <= 1'b1;
                r_obad  <= 1'b1;
            end else if (r_state == S_SIGN) begin
                r_ochar <= MINUS_CHAR;
                r_olast <= 1'b0;
                r_obad  <= 1'b0;
            end else if (r_state == S_EMIT) begin
                r_ochar <= digit_char(r_rd);
                r_olast <= (r_depth == '0);
                r_obad  <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.character = r_ochar;
    assign o_out.last      = r_olast;
    assign o_out.bad_radix = r_obad;

endmodule

>>> sv/integer_to_radix_text.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                               Handshake
// i_in      in   value[VALUE_BITS] signed, radix[6]    valid/ready
// o_out     out  character[8], last, bad_radix         valid/ready
//
// A request enters a two-entry queue; the converter then takes it on its own.
// Every digit comes from the shared remainder unit and goes onto the digit stack;
// once all are in, the sign step runs whether or not a minus sign is sent,
// and each digit is then read back from the stack and emitted, most significant first.
// A bad radix skips the division and gives one result once it leaves the queue.
// Reset is synchronous and clears the queue, the sequencer and the output valid.
module integer_to_radix_text
    import itr_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itr_in_if.sink    i_in,
    itr_out_if.source o_out
);

    localparam int unsigned ITEM_W = VALUE_BITS + RADIX_BITS + $bits(t_cls);

    logic              push;
    logic [ITEM_W-1:0] push_data;
    logic              full;
    logic              pop;
    logic              q_valid;
    logic [ITEM_W-1:0] q_data;

    itr_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_in        (i_in),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    itr_fifo #(.WIDTH(ITEM_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    itr_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_radix |-> o_out.last && (o_out.character == 8'd0))
        else $error("bad radix result is not a single zero character");

    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.bad_radix |->
            (o_out.character == MINUS_CHAR)
            || ((o_out.character >= 8'h30) && (o_out.character <= 8'h39))
            || ((o_out.character >= 8'h61) && (o_out.character <= 8'h7A)))
        else $error("character is neither a sign nor a digit");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.character == MINUS_CHAR) |-> !o_out.last)
        else $error("minus sign flagged as last character");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top
    import itr_pkg::*;
;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned CYCLE_LIMIT = 800000;
    // Margin after the last expected character, so that any straggler is still caught.
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [RADIX_BITS-1:0]     radix;
    } t_conversion;

    typedef struct {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
        logic                 bad_radix;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    itr_in_if #(.VALUE_BITS(VALUE_W)) in_ch ();
    itr_out_if out_ch ();

    integer_to_radix_text #(
        .VALUE_BITS(VALUE_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_conversion pending_conversions[$];
    t_text_char  expected_text[$];
    t_conversion next_conversion;
    t_text_char  oldest_char;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = ~i_clk;
    end

    // Appends the characters that one conversion must produce.
    function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_BITS-1:0] radix);
        logic [VALUE_W-1:0]    magnitude;
        logic [DIGIT_BITS-1:0] digits[VALUE_W];
        logic [DIGIT_BITS-1:0] d;
        int                    depth;
        t_text_char            c;
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            c.character = '0;
            c.last      = 1'b1;
            c.bad_radix = 1'b1;
            expected_text.push_back(c);
            return;
        end
        // Unsigned negation also handles the most negative value.
        magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
        depth = 0;
        do begin
            digits[depth] = DIGIT_BITS'(magnitude % VALUE_W'(radix));
            depth++;
            magnitude = magnitude / VALUE_W'(radix);
        end while (magnitude != 0 && depth < VALUE_W);
        c.bad_radix = 1'b0;
        if (value[VALUE_W-1]) begin
            c.character = MINUS_CHAR;
            c.last      = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = depth - 1; k >= 0; k--) begin
            d = digits[k];
            c.character = (d < TEN) ? ZERO_CHAR + CHAR_BITS'(d)
                                    : ALPHA_CHAR + CHAR_BITS'(d - TEN);
            c.last      = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    task automatic queue_conversion(input logic [VALUE_W-1:0] value,
                                    input logic [RADIX_BITS-1:0] radix);
        t_conversion req;
        req.value = value;
        req.radix = radix;
        pending_conversions.push_back(req);
    endtask

    task automatic queue_random_conversions(input int unsigned count);
        logic [VALUE_W-1:0]    value;
        logic [RADIX_BITS-1:0] radix;
        int unsigned           kind;
        for (int unsigned n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            if (kind <= 4) begin
                value = $urandom;
            end else if (kind <= 6) begin
                value = $urandom_range(1000);
                if ($urandom_range(1)) begin
                    value = -value;
                end
            end else if (kind == 7) begin
                case ($urandom_range(4))
                    0: value = '0;
                    1: value = '1;
                    2: value = {1'b0, {(VALUE_W-1){1'b1}}};
                    3: value = {1'b1, {(VALUE_W-1){1'b0}}};
                    default: value = 1;
                endcase
            end else begin
                // Spread the digit count across its whole range.
                value = $urandom >> $urandom_range(VALUE_W - 1);
                if ($urandom_range(1)) begin
                    value = -value;
                end
            end
            if ($urandom_range(9) == 0) begin
                radix = $urandom_range(1) ? RADIX_BITS'($urandom_range(1))
                                          : RADIX_BITS'($urandom_range(63, 37));
            end else begin
                radix = RADIX_BITS'($urandom_range(36, 2));
            end
            queue_conversion(value, radix);
        end
    endtask

    task automatic wait_until_sent();
        while (pending_conversions.size() != 0 || in_ch.valid) begin
            @(posedge i_clk);
        end
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_text(in_ch.value, in_ch.radix);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_conversions.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                    next_conversion = pending_conversions.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.value <= next_conversion.value;
                    in_ch.radix <= next_conversion.radix;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_text.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("unexpected character: got char=%h last=%b bad=%b",
                                 out_ch.character, out_ch.last, out_ch.bad_radix);
                    end
                end else begin
                    oldest_char = expected_text.pop_front();
                    if (out_ch.character !== oldest_char.character ||
                        out_ch.last !== oldest_char.last ||
                        out_ch.bad_radix !== oldest_char.bad_radix) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("mismatch: expected char=%h last=%b bad=%b,",
                                     oldest_char.character, oldest_char.last,
                                     oldest_char.bad_radix,
                                     " got char=%h last=%b bad=%b",
                                     out_ch.character, out_ch.last,
                                     out_ch.bad_radix);
                        end
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        cycle_count    = 0;
        mismatch_count = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 48;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.radix    = '0;
        out_ch.ready   = 1'b0;

        // Zero in several bases, the extremes, and each invalid radix class.
        queue_conversion(32'd0, 6'd10);
        queue_conversion(32'd0, 6'd2);
        queue_conversion(32'd0, 6'd36);
        queue_conversion(32'h7FFF_FFFF, 6'd2);
        queue_conversion(32'h7FFF_FFFF, 6'd36);
        queue_conversion(32'h8000_0000, 6'd2);
        queue_conversion(32'h8000_0000, 6'd10);
        queue_conversion(32'h8000_0000, 6'd16);
        queue_conversion(32'hFFFF_FFFF, 6'd10);
        queue_conversion(32'hFFFF_FFFF, 6'd2);
        queue_conversion(32'd1, 6'd2);
        queue_conversion(32'd35, 6'd36);
        queue_conversion(32'd36, 6'd36);
        queue_conversion(32'd123456789, 6'd10);
        queue_conversion(32'd255, 6'd16);
        queue_conversion(-32'sd255, 6'd16);
        queue_conversion(32'hAAAA_AAAA, 6'd8);
        queue_conversion(32'h5555_5555, 6'd7);
        queue_conversion(32'd42, 6'd0);
        queue_conversion(32'hFFFF_FFFF, 6'd1);
        queue_conversion(32'd99, 6'd37);
        queue_conversion(32'h8000_0000, 6'd63);
        queue_random_conversions(90);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_until_sent();
        send_idle_pct <= 48;
        recv_idle_pct <= 33;
        queue_random_conversions(105);
        wait_until_sent();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random_conversions(105);
        wait_until_sent();

        while (expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_text.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
sv/itr_pkg.sv
sv/itr_if.sv
sv/itr_front.sv
sv/itr_fifo.sv
sv/itr_back.sv
sv/integer_to_radix_text.sv
test/tb_top.sv
